@@ hw/rtl/adbg_pkg.sv @@
// Shared widths, reset values and codes of the adaptive dispatch band governor.
package adbg_pkg;

   localparam int PIX_W     = 25;
   localparam int TIME_W    = 32;
   localparam int RATIO_W   = 10;
   localparam int ROWS_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int RATIO_FRAC_BITS    = 8;
   localparam int TIME_FRACTION_BITS = 8;

   localparam logic [PIX_W-1:0]   PIXEL_LIMIT        = PIX_W'(16777216);
   localparam logic [TIME_W-1:0]  TARGET_TIME_RESET  = TIME_W'(16 << TIME_FRACTION_BITS);
   localparam logic [TIME_W-1:0]  STOP_TIME_RESET    = TIME_W'(1000 << TIME_FRACTION_BITS);
   localparam logic [RATIO_W-1:0] GROWTH_RATIO_RESET = RATIO_W'(512);
   localparam logic [PIX_W-1:0]   MAX_PIXELS_RESET   = PIXEL_LIMIT;
   localparam logic [ROWS_W-1:0]  MAX_ROWS_RESET     = ROWS_W'(65535);

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TIME  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_TIME    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH_RATIO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PIXELS   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ROWS     = CSR_IDX_W'(4);

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

endpackage

@@ hw/rtl/adaptive_dispatch_band_governor_unit.sv @@
// Top level of the adaptive dispatch band governor: sequencer, state and channels.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  op, pixels, time, invalid flag, rows, width
//   rsp      out        rsp_valid/rsp_stall  accepted, rows, budget, safety flag, cap, error
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One transaction is taken at a time. A record transaction passes product, update
// and load in turn. A valid query waits for the 25 steps of the serial divider that
// splits the allowance by the band width; a bad query goes straight to load with an
// error. The next transaction is taken once the unit is back in idle after a load.
// Reset is synchronous and restores registers and governor state.
// A result waits in the output register while rsp_stall is high; the next
// transaction is already accepted and finishes once the register is free.
module adaptive_dispatch_band_governor_unit (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [adbg_pkg::PIX_W-1:0]          req_dispatched_pixels,
   input  logic [adbg_pkg::TIME_W-1:0]         req_measured_time,
   input  logic                                req_time_invalid,
   input  logic [adbg_pkg::ROWS_W-1:0]         req_remaining_rows,
   input  logic [adbg_pkg::PIX_W-1:0]          req_band_width,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [adbg_pkg::ROWS_W-1:0]         rsp_rows,
   output logic [adbg_pkg::PIX_W-1:0]          rsp_pixel_budget,
   output logic                                rsp_safety_active,
   output logic [adbg_pkg::PIX_W-1:0]          rsp_safety_cap,
   output logic                                rsp_request_error,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [adbg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [adbg_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int PROD_W = adbg_pkg::PIX_W + adbg_pkg::RATIO_W;
   localparam int SCL_W  = PROD_W - adbg_pkg::RATIO_FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   state_type                          state_ff;

   logic [adbg_pkg::TIME_W-1:0]        target_time_ff;
   logic [adbg_pkg::TIME_W-1:0]        stop_time_ff;
   logic [adbg_pkg::RATIO_W-1:0]       growth_ratio_ff;
   logic [adbg_pkg::PIX_W-1:0]         max_pixels_ff;
   logic [adbg_pkg::ROWS_W-1:0]        max_rows_ff;

   logic [adbg_pkg::PIX_W-1:0]         budget_ff;
   logic                               safety_ff;
   logic [adbg_pkg::PIX_W-1:0]         cap_ff;

   logic                               op_ff;
   logic [adbg_pkg::PIX_W-1:0]         pix_ff;
   logic [adbg_pkg::TIME_W-1:0]        time_ff;
   logic                               inval_ff;
   logic [adbg_pkg::ROWS_W-1:0]        rem_ff;
   logic [adbg_pkg::PIX_W-1:0]         bw_ff;
   logic [PROD_W-1:0]                  prod_ff;

   logic                               res_acc_ff;
   logic [adbg_pkg::ROWS_W-1:0]        res_rows_ff;
   logic                               res_err_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_acc_ff;
   logic [adbg_pkg::ROWS_W-1:0]        rsp_rows_ff;
   logic [adbg_pkg::PIX_W-1:0]         rsp_budget_ff;
   logic                               rsp_safety_ff;
   logic [adbg_pkg::PIX_W-1:0]         rsp_cap_ff;
   logic                               rsp_err_ff;

   logic                               query_bad;
   logic [adbg_pkg::PIX_W-1:0]         allowance;
   logic                               div_start;
   logic                               div_done;
   logic [adbg_pkg::PIX_W-1:0]         div_quotient;

   logic                               over_stop;
   logic                               rec_reject;
   logic                               rec_safety;
   logic [adbg_pkg::PIX_W-1:0]         half_pix;
   logic [adbg_pkg::PIX_W-1:0]         reduce;
   logic [adbg_pkg::PIX_W-1:0]         new_cap;
   logic [SCL_W-1:0]                   scaled;
   logic [adbg_pkg::PIX_W-1:0]         clamped;
   logic [adbg_pkg::PIX_W-1:0]         quo_min1;
   logic [adbg_pkg::ROWS_W-1:0]        row_limit;
   logic [adbg_pkg::ROWS_W-1:0]        rows_calc;
   logic                               out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Query preconditions and the allowance handed to the divider.
   assign query_bad = (rem_ff == '0) || (bw_ff == '0) || (bw_ff > max_pixels_ff);
   assign allowance = safety_ff ? adbg_pkg::PIX_W'(1)
                    : ((target_time_ff != '0) ? budget_ff : max_pixels_ff);
   assign div_start = (state_ff == ST_EVAL) && (op_ff == adbg_pkg::OP_QUERY) && !query_bad;

   adbg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (allowance),
      .divisor  (bw_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      over_stop  = time_ff > stop_time_ff;
      rec_reject = inval_ff || (pix_ff > max_pixels_ff)
                 || (over_stop && (pix_ff == adbg_pkg::PIX_W'(1)));
      rec_safety = (time_ff == '0) || over_stop;
      half_pix   = {1'b0, pix_ff[adbg_pkg::PIX_W-1:1]};
      if (time_ff == '0 || half_pix == '0) begin
         reduce = adbg_pkg::PIX_W'(1);
      end else begin
         reduce = half_pix;
      end
      new_cap = (reduce < cap_ff) ? reduce : cap_ff;
      priority if (time_ff < target_time_ff) begin
         scaled = prod_ff[PROD_W-1:adbg_pkg::RATIO_FRAC_BITS];
      end else if (time_ff > target_time_ff) begin
         scaled = SCL_W'(half_pix);
      end else begin
         scaled = SCL_W'(pix_ff);
      end
      if (scaled > SCL_W'(max_pixels_ff)) begin
         clamped = max_pixels_ff;
      end else begin
         clamped = scaled[adbg_pkg::PIX_W-1:0];
      end
      if (clamped == '0) begin
         clamped = adbg_pkg::PIX_W'(1);
      end
   end

   always_comb begin
      quo_min1  = (div_quotient == '0) ? adbg_pkg::PIX_W'(1) : div_quotient;
      row_limit = (rem_ff < max_rows_ff) ? rem_ff : max_rows_ff;
      if (adbg_pkg::PIX_W'(row_limit) < quo_min1) begin
         rows_calc = row_limit;
      end else begin
         rows_calc = quo_min1[adbg_pkg::ROWS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         target_time_ff  <= adbg_pkg::TARGET_TIME_RESET;
         stop_time_ff    <= adbg_pkg::STOP_TIME_RESET;
         growth_ratio_ff <= adbg_pkg::GROWTH_RATIO_RESET;
         max_pixels_ff   <= adbg_pkg::MAX_PIXELS_RESET;
         max_rows_ff     <= adbg_pkg::MAX_ROWS_RESET;
         budget_ff       <= adbg_pkg::PIXEL_LIMIT;
         safety_ff       <= 1'b0;
         cap_ff          <= adbg_pkg::PIXEL_LIMIT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               adbg_pkg::CSR_TARGET_TIME:  target_time_ff  <= csr_data;
               adbg_pkg::CSR_STOP_TIME:    stop_time_ff    <= csr_data;
               adbg_pkg::CSR_GROWTH_RATIO:
                  growth_ratio_ff <= csr_data[adbg_pkg::RATIO_W-1:0];
               adbg_pkg::CSR_MAX_PIXELS:
                  max_pixels_ff <= csr_data[adbg_pkg::PIX_W-1:0];
               adbg_pkg::CSR_MAX_ROWS:
                  max_rows_ff <= csr_data[adbg_pkg::ROWS_W-1:0];
               default: begin
               end
            endcase
         end

         if (state_ff == ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  pix_ff   <= req_dispatched_pixels;
                  time_ff  <= req_measured_time;
                  inval_ff <= req_time_invalid;
                  rem_ff   <= req_remaining_rows;
                  bw_ff    <= req_band_width;
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               res_acc_ff  <= 1'b0;
               res_rows_ff <= '0;
               res_err_ff  <= 1'b0;
               if (op_ff == adbg_pkg::OP_RECORD) begin
                  prod_ff  <= PROD_W'(pix_ff) * PROD_W'(growth_ratio_ff);
                  state_ff <= ST_APPLY;
               end else if (query_bad) begin
                  res_err_ff <= 1'b1;
                  state_ff   <= ST_RESULT;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_APPLY: begin
               priority if (pix_ff == '0) begin
                  res_err_ff <= 1'b1;
               end else if (rec_reject) begin
                  budget_ff <= adbg_pkg::PIX_W'(1);
               end else if (rec_safety) begin
                  safety_ff  <= 1'b1;
                  cap_ff     <= new_cap;
                  budget_ff  <= new_cap;
                  res_acc_ff <= 1'b1;
               end else begin
                  res_acc_ff <= 1'b1;
                  if (target_time_ff != '0) begin
                     budget_ff <= clamped;
                  end
               end
               state_ff <= ST_RESULT;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  res_rows_ff <= rows_calc;
                  state_ff    <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (out_free) begin
                  rsp_acc_ff    <= res_acc_ff;
                  rsp_rows_ff   <= res_rows_ff;
                  rsp_budget_ff <= budget_ff;
                  rsp_safety_ff <= safety_ff;
                  rsp_cap_ff    <= cap_ff;
                  rsp_err_ff    <= res_err_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_rows          = rsp_rows_ff;
   assign rsp_pixel_budget  = rsp_budget_ff;
   assign rsp_safety_active = rsp_safety_ff;
   assign rsp_safety_cap    = rsp_cap_ff;
   assign rsp_request_error = rsp_err_ff;

endmodule

@@ hw/rtl/adbg_divider.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle.
module adbg_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [adbg_pkg::PIX_W-1:0]  dividend,
   input  logic [adbg_pkg::PIX_W-1:0]  divisor,
   output logic                        done,
   output logic [adbg_pkg::PIX_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(adbg_pkg::PIX_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [adbg_pkg::PIX_W:0]    rem_ff;
   logic [adbg_pkg::PIX_W-1:0]  quo_ff;
   logic [adbg_pkg::PIX_W-1:0]  div_ff;
   logic [adbg_pkg::PIX_W:0]    shifted;
   logic [adbg_pkg::PIX_W+1:0]  trial;

   assign shifted = {rem_ff[adbg_pkg::PIX_W-1:0], quo_ff[adbg_pkg::PIX_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(adbg_pkg::PIX_W - 1);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            if (trial[adbg_pkg::PIX_W+1]) begin
               rem_ff <= shifted;
               quo_ff <= {quo_ff[adbg_pkg::PIX_W-2:0], 1'b0};
            end else begin
               rem_ff <= trial[adbg_pkg::PIX_W:0];
               quo_ff <= {quo_ff[adbg_pkg::PIX_W-2:0], 1'b1};
            end
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
